FILE: src/assert_macros.svh
// Assertion macros used by the divider's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SID_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Checks that a trigger at one edge is followed by a condition at the next edge.
`define SID_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

FILE: src/sid_pkg.sv
// Shared constants, payload types and control types of the signed divider.
package sid_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] WORD_ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
	localparam logic [DATA_WIDTH-1:0] WORD_ALL = {DATA_WIDTH{1'b1}};

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] dividend;
		logic signed [DATA_WIDTH-1:0] divisor;
	} sid_req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quotient;
		logic                         overflowed;
		logic                         divide_by_zero;
	} sid_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIX
	} sid_state_t;

	// Control from the sequencer to the row of cells.
	typedef struct packed {
		logic load;
		logic run;
	} sid_row_ctl_t;

	// Control broadcast by the row to every cell.
	typedef struct packed {
		logic load;
		logic run;
		logic ge;
	} sid_cell_ctl_t;

endpackage

FILE: src/signed_int32_divider.sv
// Top level of the signed truncating integer divider.
//
// Signed two's-complement divider with truncation toward zero. A request
// carries dividend and divisor; exactly one response comes back with the
// quotient and two flags. A zero divisor gives quotient 0 with divide_by_zero
// set; the most negative value divided by minus one saturates to the largest
// positive value with overflowed set. The remainder is not returned. Both
// channels use valid/stall handshakes. The divider works on one request at a
// time. The operand magnitudes are loaded into the row of bit cells at the
// edge that accepts the request. The row then yields one quotient bit per
// cycle until all DATA_WIDTH bits are formed; then the fix-up state applies
// the sign fix-up and writes the response register. The input stall drops in
// the cycle after the response register is written, so a new request is only
// accepted once the current one has written its response. A finished
// response waiting on a stalled output does not block the next request; the
// fix-up step only waits while an earlier response is still held in the
// response register.
`include "assert_macros.svh"

module signed_int32_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  sid_pkg::sid_req_t req,
	input  logic              req_valid,
	output logic              req_stall,
	output sid_pkg::sid_rsp_t rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall
);

	localparam int W     = sid_pkg::DATA_WIDTH;
	localparam int CNT_W = sid_pkg::CNT_W;

	// Absolute value in W bits; the most negative value maps to 2^(W-1).
	function automatic logic [W-1:0] magnitude(input logic [W-1:0] x);
		return x[W-1] ? ((~x) + sid_pkg::WORD_ONE) : x;
	endfunction

	sid_pkg::sid_state_t   state_q;
	sid_pkg::sid_state_t   state_next;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic                  ovf_q;
	logic                  dbz_q;
	sid_pkg::sid_rsp_t     rsp_q;
	logic                  rsp_valid_q;
	logic                  req_acc;
	logic                  rsp_take;
	logic                  rsp_load;
	sid_pkg::sid_row_ctl_t row_ctl;
	logic [W-1:0]          num_mag;
	logic [W-1:0]          den_mag;
	logic [W-1:0]          quo_mag;
	logic [W-1:0]          quo_fixed;

	assign req_stall = (state_q != sid_pkg::ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_take  = rsp_valid_q && !rsp_stall;

	assign num_mag = magnitude(req.dividend);
	assign den_mag = magnitude(req.divisor);

	sid_row u_row (
		.clk     (clk),
		.ctl     (row_ctl),
		.num_mag (num_mag),
		.den_mag (den_mag),
		.quo_mag (quo_mag)
	);

	// Sign fix-up and the two special cases, applied in the fix-up state.
	always_comb begin
		if (ovf_q) begin
			quo_fixed = sid_pkg::WORD_MAX;
		end else if (dbz_q) begin
			quo_fixed = '0;
		end else if (neg_q) begin
			quo_fixed = (~quo_mag) + sid_pkg::WORD_ONE;
		end else begin
			quo_fixed = quo_mag;
		end
	end

	// Sequencer: next state, row control and response load.
	always_comb begin
		state_next = state_q;
		row_ctl    = '{load: 1'b0, run: 1'b0};
		rsp_load   = 1'b0;
		case (state_q)
			sid_pkg::ST_IDLE: begin
				if (req_acc) begin
					row_ctl.load = 1'b1;
					state_next   = sid_pkg::ST_RUN;
				end
			end
			sid_pkg::ST_RUN: begin
				row_ctl.run = 1'b1;
				if (cnt_q == '0) begin
					state_next = sid_pkg::ST_FIX;
				end
			end
			sid_pkg::ST_FIX: begin
				// The response register must be empty or emptying this cycle.
				if (!rsp_valid_q || rsp_take) begin
					rsp_load   = 1'b1;
					state_next = sid_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = sid_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sid_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req_acc) begin
			cnt_q <= CNT_W'(W - 1);
		end else if (state_q == sid_pkg::ST_RUN) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Special-case flags are captured with the operands.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			neg_q <= req.dividend[W-1] ^ req.divisor[W-1];
			dbz_q <= (req.divisor == '0);
			ovf_q <= (req.dividend == sid_pkg::WORD_MIN) && (req.divisor == sid_pkg::WORD_ALL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.quotient       <= quo_fixed;
			rsp_q.overflowed     <= ovf_q;
			rsp_q.divide_by_zero <= dbz_q && !ovf_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	`SID_ASSERT_NEXT(a_acc_starts_run, req_acc,
		(state_q == sid_pkg::ST_RUN) && (cnt_q == CNT_W'(W - 1)),
		"accepted request did not start a full division")
	`SID_ASSERT(a_flags_exclusive,
		!(rsp_valid_q && rsp_q.overflowed && rsp_q.divide_by_zero),
		"overflow and divide-by-zero reported together")
	`SID_ASSERT(a_ovf_saturates,
		!(rsp_valid_q && rsp_q.overflowed) || (rsp_q.quotient == sid_pkg::WORD_MAX),
		"overflow response not saturated")
	`SID_ASSERT(a_dbz_zero,
		!(rsp_valid_q && rsp_q.divide_by_zero) || (rsp_q.quotient == '0),
		"divide-by-zero response has a nonzero quotient")

endmodule

FILE: src/sid_cell.sv
// One bit slice of the divider: remainder, quotient and divisor bit with its subtract stage.
module sid_cell (
	input  logic                   clk,
	input  sid_pkg::sid_cell_ctl_t ctl,
	input  logic                   num_bit,
	input  logic                   den_bit,
	input  logic                   rem_low,
	input  logic                   quo_low,
	input  logic                   borrow_low,
	output logic                   rem,
	output logic                   quo,
	output logic                   borrow
);

	logic rem_q;
	logic quo_q;
	logic den_q;
	logic diff;

	// Full subtractor on the shifted remainder bit.
	always_comb begin
		diff   = rem_low ^ den_q ^ borrow_low;
		borrow = (~rem_low & (den_q | borrow_low)) | (rem_low & den_q & borrow_low);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= 1'b0;
			quo_q <= num_bit;
			den_q <= den_bit;
		end else if (ctl.run) begin
			rem_q <= ctl.ge ? diff : rem_low;
			quo_q <= quo_low;
		end
	end

	assign rem = rem_q;
	assign quo = quo_q;

endmodule

FILE: src/sid_row.sv
// Row of bit cells that performs one restoring division step per cycle while run is set.
module sid_row (
	input  logic                                clk,
	input  sid_pkg::sid_row_ctl_t               ctl,
	input  logic [sid_pkg::DATA_WIDTH-1:0]      num_mag,
	input  logic [sid_pkg::DATA_WIDTH-1:0]      den_mag,
	output logic [sid_pkg::DATA_WIDTH-1:0]      quo_mag
);

	localparam int W = sid_pkg::DATA_WIDTH;

	logic [W-1:0]           rem_w;
	logic [W-1:0]           quo_w;
	logic [W-1:0]           borrow_w;
	logic                   ge;
	sid_pkg::sid_cell_ctl_t cell_ctl;

	// The shifted remainder is one bit wider than the row; its top bit is the
	// old remainder MSB, so the trial subtract fits unless it borrows past it.
	assign ge       = ~(borrow_w[W-1] & ~rem_w[W-1]);
	assign cell_ctl = '{load: ctl.load, run: ctl.run, ge: ge};

	for (genvar i = 0; i < W; i++) begin : g_cell
		logic rem_low;
		logic quo_low;
		logic borrow_low;

		if (i == 0) begin : g_first
			assign rem_low    = quo_w[W-1];
			assign quo_low    = ge;
			assign borrow_low = 1'b0;
		end else begin : g_next
			assign rem_low    = rem_w[i-1];
			assign quo_low    = quo_w[i-1];
			assign borrow_low = borrow_w[i-1];
		end

		sid_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.num_bit    (num_mag[i]),
			.den_bit    (den_mag[i]),
			.rem_low    (rem_low),
			.quo_low    (quo_low),
			.borrow_low (borrow_low),
			.rem        (rem_w[i]),
			.quo        (quo_w[i]),
			.borrow     (borrow_w[i])
		);
	end

	assign quo_mag = quo_w;

endmodule
